### rtl/spa_pkg.sv
// Shared types and constants of the sparse polynomial adder.
`default_nettype none
package spa_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int COEFF_W       = 16;
    localparam int EXP_W         = 8;
    localparam int SUM_W         = 17;

    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic [EXP_W-1:0]          exponent;
    } t_term;

    // One classified input beat handed from front to back.
    typedef struct packed {
        logic  store;
        logic  sel;
        t_term term;
        logic  merge;
        logic  ovf;
    } t_cmd;

endpackage
`default_nettype wire

### rtl/spa_ifs.sv
// Valid/ready channel interfaces for input terms and sum terms.
`default_nettype none
interface spa_in_if;
    logic                                valid;
    logic                                ready;
    logic                                which_poly;
    logic signed [spa_pkg::COEFF_W-1:0]  coeff;
    logic [spa_pkg::EXP_W-1:0]           exponent;
    logic                                last_term;

    modport source (output valid, which_poly, coeff, exponent, last_term, input ready);
    modport sink (input valid, which_poly, coeff, exponent, last_term, output ready);
endinterface

interface spa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [spa_pkg::SUM_W-1:0]    sum_coeff;
    logic [spa_pkg::EXP_W-1:0]           sum_exponent;
    logic                                last_result;
    logic                                dropped_terms;

    modport source (output valid, sum_coeff, sum_exponent, last_result, dropped_terms,
                    input ready);
    modport sink (input valid, sum_coeff, sum_exponent, last_result, dropped_terms,
                  output ready);
endinterface
`default_nettype wire

### rtl/spa_front.sv
// Front end: accepts terms, tracks fill and completion, issues store/merge commands.
`default_nettype none
module spa_front #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    spa_in_if.sink       i_in,
    output spa_pkg::t_cmd o_cmd,
    output logic         o_push,
    input  wire          i_full
);
    localparam int CW = $clog2(MAX_TERMS + 1);

    logic [CW-1:0] r_cnt [2];
    logic [1:0]    r_done;
    logic          r_ovf;

    logic          w_acc;
    logic          w_sel;
    logic          w_st;
    logic [1:0]    n_done;
    logic          w_merge;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_sel      = i_in.which_poly;
    assign w_st       = r_cnt[w_sel] < CW'(MAX_TERMS);

    always_comb begin
        n_done = r_done;
        if (i_in.last_term) begin
            n_done[w_sel] = 1'b1;
        end
    end

    assign w_merge = &n_done;
    assign o_push  = w_acc && !r_done[w_sel] && (w_st || w_merge);

    always_comb begin
        o_cmd.store          = w_st;
        o_cmd.sel            = w_sel;
        o_cmd.term.coeff     = i_in.coeff;
        o_cmd.term.exponent  = i_in.exponent;
        o_cmd.merge          = w_merge;
        o_cmd.ovf            = r_ovf || !w_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_done   <= '0;
            r_ovf    <= 1'b0;
        end else if (w_acc && !r_done[w_sel]) begin
            if (w_merge) begin
                r_cnt[0] <= '0;
                r_cnt[1] <= '0;
                r_done   <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_done <= n_done;
                if (w_st) begin
                    r_cnt[w_sel] <= r_cnt[w_sel] + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/spa_queue.sv
// Two-entry command queue between front and back.
`default_nettype none
module spa_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  spa_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output spa_pkg::t_cmd o_cmd,
    input  wire           i_pop
);
    spa_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    logic          w_push;
    logic          w_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/spa_back.sv
// Back end: term stores and the exponent merge that emits sum terms.
`default_nettype none
module spa_back #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  spa_pkg::t_cmd i_cmd,
    output logic          o_pop,
    spa_out_if.source     o_out
);
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } t_state;

    t_state         r_state;
    spa_pkg::t_term r_mem_a [MAX_TERMS];
    spa_pkg::t_term r_mem_b [MAX_TERMS];
    logic [CW-1:0]  r_wp_a;
    logic [CW-1:0]  r_wp_b;
    logic [CW-1:0]  r_cnt_a;
    logic [CW-1:0]  r_cnt_b;
    logic [CW-1:0]  r_i;
    logic [CW-1:0]  r_j;
    logic           r_ovf;

    logic                              r_out_valid;
    logic signed [spa_pkg::SUM_W-1:0]  r_out_coeff;
    logic [spa_pkg::EXP_W-1:0]         r_out_exp;
    logic                              r_out_last;
    logic                              r_out_drop;

    logic                              w_idle;
    logic                              w_load;
    logic                              w_a_ok;
    logic                              w_b_ok;
    logic                              w_take_a;
    logic                              w_take_b;
    spa_pkg::t_term                    w_ta;
    spa_pkg::t_term                    w_tb;
    logic signed [spa_pkg::SUM_W-1:0]  w_ca;
    logic signed [spa_pkg::SUM_W-1:0]  w_cb;
    logic signed [spa_pkg::SUM_W-1:0]  n_coeff;
    logic [spa_pkg::EXP_W-1:0]         n_exp;
    logic [CW-1:0]                     n_i;
    logic [CW-1:0]                     n_j;
    logic                              n_last;
    logic [CW-1:0]                     w_wp_a_nx;
    logic [CW-1:0]                     w_wp_b_nx;

    assign w_idle = r_state == ST_IDLE;
    assign o_pop  = w_idle && i_valid;
    assign w_load = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.sum_coeff     = r_out_coeff;
    assign o_out.sum_exponent  = r_out_exp;
    assign o_out.last_result   = r_out_last;
    assign o_out.dropped_terms = r_out_drop;

    assign w_wp_a_nx = r_wp_a + CW'(i_cmd.store && !i_cmd.sel);
    assign w_wp_b_nx = r_wp_b + CW'(i_cmd.store && i_cmd.sel);

    // Merge step: pick the greater head exponent, add heads on a tie.
    always_comb begin
        w_ta     = r_mem_a[r_i[AW-1:0]];
        w_tb     = r_mem_b[r_j[AW-1:0]];
        w_a_ok   = r_i < r_cnt_a;
        w_b_ok   = r_j < r_cnt_b;
        w_ca     = spa_pkg::SUM_W'(w_ta.coeff);
        w_cb     = spa_pkg::SUM_W'(w_tb.coeff);
        w_take_a = w_a_ok && (!w_b_ok || w_ta.exponent >= w_tb.exponent);
        w_take_b = w_b_ok && (!w_a_ok || w_tb.exponent >= w_ta.exponent);
        n_coeff  = (w_take_a ? w_ca : '0) + (w_take_b ? w_cb : '0);
        n_exp    = w_take_a ? w_ta.exponent : w_tb.exponent;
        n_i      = r_i + CW'(w_take_a);
        n_j      = r_j + CW'(w_take_b);
        n_last   = (n_i >= r_cnt_a) && (n_j >= r_cnt_b);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.store) begin
            if (i_cmd.sel) begin
                r_mem_b[r_wp_b[AW-1:0]] <= i_cmd.term;
            end else begin
                r_mem_a[r_wp_a[AW-1:0]] <= i_cmd.term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MERGE && w_load) begin
            r_out_coeff <= n_coeff;
            r_out_exp   <= n_exp;
            r_out_last  <= n_last;
            r_out_drop  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp_a      <= '0;
            r_wp_b      <= '0;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && w_idle) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_wp_a <= w_wp_a_nx;
                        r_wp_b <= w_wp_b_nx;
                        if (i_cmd.merge) begin
                            r_cnt_a <= w_wp_a_nx;
                            r_cnt_b <= w_wp_b_nx;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_ovf   <= i_cmd.ovf;
                            r_state <= ST_MERGE;
                        end
                    end
                end
                ST_MERGE: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_i         <= n_i;
                        r_j         <= n_j;
                        if (n_last) begin
                            r_wp_a  <= '0;
                            r_wp_b  <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/sparse_polynomial_adder_top.sv
// Top level of the sparse polynomial adder.
// Terms of two polynomials enter on i_in, one beat per cycle while ready is high,
// each tagged by which_poly and closed by last_term; up to MAX_TERMS terms per
// polynomial are kept, extra ones are dropped and flagged on every sum term of
// that run. The beat that completes the second polynomial starts the merge,
// which emits one sum term per cycle on o_out while o_out is ready, in
// descending exponent order (equal exponents added, zero sums kept). The merge
// is done by the single merge unit in the back end, with at most one sum term
// per stored term. While the merge runs, the two-entry command queue still takes
// beats; further terms wait once it is full.
`default_nettype none
module sparse_polynomial_adder_top #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    spa_in_if.sink     i_in,
    spa_out_if.source  o_out
);
    spa_pkg::t_cmd w_push_cmd;
    spa_pkg::t_cmd w_pop_cmd;
    logic          w_push;
    logic          w_full;
    logic          w_q_valid;
    logic          w_pop;

    spa_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (w_push_cmd),
        .o_push  (w_push),
        .i_full  (w_full)
    );

    spa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd),
        .i_pop   (w_pop)
    );

    spa_back #(.MAX_TERMS(MAX_TERMS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_pop_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
